@@ rtl/rcf_pkg.sv @@
// Shared types, constants and helper functions for the rectangle clip/fill front end.
// Used by rcf_region_gen and rect_clip_fill_command; no other dependencies.
package rcf_pkg;

    // Surface limit and field widths.
    localparam int MAX_DIM    = 4096;
    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int SPAN_W     = 16;
    localparam int COLOR_W    = 24;
    localparam int PIX_W      = 32;
    localparam int CALC_W     = 20;
    localparam int NUM_SLOTS  = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // Command kinds carried in the input tuser.
    typedef enum logic [1:0] {
        ACT_PIXEL   = 2'd0,
        ACT_FILL    = 2'd1,
        ACT_OUTLINE = 2'd2,
        ACT_CLEAR   = 2'd3
    } t_action;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SURF_W   = 3'd0,
        REG_SURF_H   = 3'd1,
        REG_DRAW_CLR = 3'd2,
        REG_CH_POS   = 3'd3,
        REG_CH_SIZE  = 3'd4
    } t_cfg_reg;

    // Current configuration.
    typedef struct packed {
        logic [DIM_W-1:0]   surf_w;
        logic [DIM_W-1:0]   surf_h;
        logic [COLOR_W-1:0] draw_color;
        logic [14:0]        ch_pos;
        logic [11:0]        ch_size;
    } t_cfg;

    // One registered draw command.
    typedef struct packed {
        t_action                  action;
        logic signed [SPAN_W-1:0] pos_x;
        logic signed [SPAN_W-1:0] pos_y;
        logic signed [SPAN_W-1:0] span_w;
        logic signed [SPAN_W-1:0] span_h;
        logic [COLOR_W-1:0]       clear_color;
    } t_cmd;

    // One clipped fill region.
    typedef struct packed {
        logic               vld;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
    } t_region;

    // Widen a signed 16-bit field to the working width.
    function automatic logic signed [CALC_W-1:0] sext(input logic [SPAN_W-1:0] v);
        return {{(CALC_W-SPAN_W){v[SPAN_W-1]}}, v};
    endfunction

    // Clip one rectangle against a surface of sw by sh pixels.
    function automatic t_region clip_rect(input logic signed [CALC_W-1:0] x,
                                          input logic signed [CALC_W-1:0] y,
                                          input logic signed [CALC_W-1:0] w,
                                          input logic signed [CALC_W-1:0] h,
                                          input logic [DIM_W-1:0]         sw,
                                          input logic [DIM_W-1:0]         sh);
        t_region                   r;
        logic signed [CALC_W-1:0]  swe;
        logic signed [CALC_W-1:0]  she;
        logic signed [CALC_W-1:0]  x0;
        logic signed [CALC_W-1:0]  x1;
        logic signed [CALC_W-1:0]  y0;
        logic signed [CALC_W-1:0]  y1;
        logic signed [CALC_W-1:0]  dx;
        logic signed [CALC_W-1:0]  dy;
        swe = {{(CALC_W-DIM_W){1'b0}}, sw};
        she = {{(CALC_W-DIM_W){1'b0}}, sh};
        x0  = (x < 0) ? '0 : x;
        x1  = x + w;
        if (x1 > swe) begin
            x1 = swe;
        end
        y0  = (y < 0) ? '0 : y;
        y1  = y + h;
        if (y1 > she) begin
            y1 = she;
        end
        dx    = x1 - x0;
        dy    = y1 - y0;
        r.vld = (w > 0) && (h > 0) && (x0 < x1) && (y0 < y1);
        r.x   = x0[COORD_W-1:0];
        r.y   = y0[COORD_W-1:0];
        r.w   = dx[DIM_W-1:0];
        r.h   = dy[DIM_W-1:0];
        return r;
    endfunction

    // Mask one 8-bit channel to its size (at most 8) and move it to its position.
    function automatic logic [PIX_W-1:0] place_chan(input logic [7:0] v,
                                                    input logic [3:0] size,
                                                    input logic [4:0] pos);
        logic [3:0] sz;
        logic [8:0] full;
        logic [7:0] mask;
        sz   = (size > 4'd8) ? 4'd8 : size;
        full = (9'd1 << sz) - 9'd1;
        mask = full[7:0];
        return {{(PIX_W-8){1'b0}}, v & mask} << pos;
    endfunction

    // Pack a 24-bit RGB colour into the native pixel layout.
    function automatic logic [PIX_W-1:0] pack_rgb(input logic [COLOR_W-1:0] rgb,
                                                  input logic [14:0]        pos,
                                                  input logic [11:0]        size);
        return place_chan(rgb[23:16], size[11:8], pos[14:10])
             | place_chan(rgb[15:8],  size[7:4],  pos[9:5])
             | place_chan(rgb[7:0],   size[3:0],  pos[4:0]);
    endfunction

endpackage

@@ rtl/rect_clip_fill_command.sv @@
// Top level of the rectangle clip/fill command front end.
// Depends on rcf_pkg and rcf_region_gen.
//
// Usage: draw commands enter on the s_axis channel (tuser carries the command
// kind, tdata the position, span and clear colour). Clipped fill regions leave on
// the m_axis channel, one word per region, with tlast on the final region of a
// command. A command that lands entirely off the surface produces no word.
// Configuration is written through i_cfg_we/i_cfg_addr/i_cfg_data, one register
// per cycle, while no command is in flight.
// Timing: an accepted command waits in the input command register until the region
// buffer is free, is then clipped into it, and its first region is on m_axis from then on.
// Throughput: one command per cycle for commands with at most one region while
// m_axis_tready is high; an outline sends one word per non-empty strip, up to four,
// through the single output port that drains the four-entry region buffer.
// Reset: synchronous, active low; clears the command and region valids and
// loads the default surface of 640 by 480 and the default colour setup.
// Stall: while m_axis_tready is low the current region holds; one further command
// waits in the input register and s_axis_tready drops after that.
module rect_clip_fill_command
    import rcf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Command input channel.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: pos_x [15:0], pos_y [31:16], span_w [47:32], span_h [63:48],
    //        clear_color [87:64]
    input  logic [87:0]           s_axis_tdata,
    // tuser: action [1:0]
    input  logic [1:0]            s_axis_tuser,
    // Region output channel.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: out_x [11:0], out_y [23:12], out_w [36:24], out_h [49:37],
    //        pixel_value [81:50], zero [87:82]
    output logic [87:0]           m_axis_tdata,
    output logic                  m_axis_tlast,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                   r_cfg;
    t_cmd                   r_cmd;
    logic                   r_cmd_vld;
    t_region                r_slot [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   r_mask;
    logic [PIX_W-1:0]       r_pix;

    t_region                gen_regions [NUM_SLOTS];
    logic [PIX_W-1:0]       gen_pixel;
    logic [NUM_SLOTS-1:0]   gen_mask;
    logic [NUM_SLOTS-1:0]   sel_onehot;
    logic [1:0]             sel_idx;
    logic [NUM_SLOTS-1:0]   rest_mask;
    logic                   in_fire;
    logic                   out_fire;
    logic                   buf_free;
    logic                   load;
    t_region                cur;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.surf_w     <= DIM_W'(640);
            r_cfg.surf_h     <= DIM_W'(480);
            r_cfg.draw_color <= 24'hFFFFFF;
            r_cfg.ch_pos     <= 15'd16640;
            r_cfg.ch_size    <= 12'd2184;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SURF_W:   r_cfg.surf_w     <= i_cfg_data[DIM_W-1:0];
                REG_SURF_H:   r_cfg.surf_h     <= i_cfg_data[DIM_W-1:0];
                REG_DRAW_CLR: r_cfg.draw_color <= i_cfg_data[COLOR_W-1:0];
                REG_CH_POS:   r_cfg.ch_pos     <= i_cfg_data[14:0];
                REG_CH_SIZE:  r_cfg.ch_size    <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // Clipping and colour packing for the registered command.
    rcf_region_gen u_gen (
        .i_cmd     (r_cmd),
        .i_cfg     (r_cfg),
        .o_regions (gen_regions),
        .o_pixel   (gen_pixel)
    );

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            gen_mask[i] = gen_regions[i].vld;
        end
    end

    // Lowest pending region goes out first.
    always_comb begin
        sel_onehot = r_mask & (~r_mask + NUM_SLOTS'(1));
        sel_idx    = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel_idx = 2'(i);
            end
        end
        rest_mask = r_mask & ~sel_onehot;
        cur       = r_slot[sel_idx];
    end

    // Handshake control.
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign buf_free      = (r_mask == '0) || (out_fire && (rest_mask == '0));
    assign load          = r_cmd_vld && buf_free;
    assign s_axis_tready = !r_cmd_vld || load;

    // Input command register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
        end else if (in_fire) begin
            r_cmd_vld <= 1'b1;
        end else if (load) begin
            r_cmd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd.action      <= t_action'(s_axis_tuser);
            r_cmd.pos_x       <= s_axis_tdata[15:0];
            r_cmd.pos_y       <= s_axis_tdata[31:16];
            r_cmd.span_w      <= s_axis_tdata[47:32];
            r_cmd.span_h      <= s_axis_tdata[63:48];
            r_cmd.clear_color <= s_axis_tdata[87:64];
        end
    end

    // Region buffer: pending mask is control, slot contents are payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (load) begin
            r_mask <= gen_mask;
        end else if (out_fire) begin
            r_mask <= rest_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot[i] <= gen_regions[i];
            end
            r_pix <= gen_pixel;
        end
    end

    // Output word.
    assign m_axis_tvalid = |r_mask;
    assign m_axis_tlast  = (rest_mask == '0);
    assign m_axis_tdata  = {6'd0, r_pix, cur.h, cur.w, cur.y, cur.x};

endmodule

@@ rtl/rcf_region_gen.sv @@
// Turns one registered draw command into up to four clipped regions and a packed pixel.
// Depends on rcf_pkg for the command, region and configuration types.
module rcf_region_gen
    import rcf_pkg::*;
(
    input  t_cmd             i_cmd,
    input  t_cfg             i_cfg,
    output t_region          o_regions [NUM_SLOTS],
    output logic [PIX_W-1:0] o_pixel
);

    logic [DIM_W-1:0]         sw_c;
    logic [DIM_W-1:0]         sh_c;
    logic signed [CALC_W-1:0] cx;
    logic signed [CALC_W-1:0] cy;
    logic signed [CALC_W-1:0] cw;
    logic signed [CALC_W-1:0] ch;
    logic signed [CALC_W-1:0] one;
    logic signed [CALC_W-1:0] full;
    t_region                  strip [NUM_SLOTS];

    // Surface size limited to the largest supported dimension.
    assign sw_c = (i_cfg.surf_w > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.surf_w;
    assign sh_c = (i_cfg.surf_h > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.surf_h;

    assign cx   = sext(i_cmd.pos_x);
    assign cy   = sext(i_cmd.pos_y);
    assign cw   = sext(i_cmd.span_w);
    assign ch   = sext(i_cmd.span_h);
    assign one  = CALC_W'(1);
    assign full = CALC_W'(MAX_DIM);

    // Outline strips: top, bottom, left, right, each clipped on its own.
    always_comb begin
        strip[0] = clip_rect(cx, cy, cw, one, sw_c, sh_c);
        strip[1] = clip_rect(cx, cy + ch - one, cw, one, sw_c, sh_c);
        strip[2] = clip_rect(cx, cy, one, ch, sw_c, sh_c);
        strip[3] = clip_rect(cx + cw - one, cy, one, ch, sw_c, sh_c);
    end

    // Region selection and colour per command kind.
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            o_regions[i] = '0;
        end
        o_pixel = pack_rgb(i_cfg.draw_color, i_cfg.ch_pos, i_cfg.ch_size);
        unique case (i_cmd.action)
            ACT_PIXEL: begin
                o_regions[0] = clip_rect(cx, cy, one, one, sw_c, sh_c);
            end
            ACT_FILL: begin
                o_regions[0] = clip_rect(cx, cy, cw, ch, sw_c, sh_c);
            end
            ACT_OUTLINE: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    o_regions[i] = strip[i];
                end
            end
            ACT_CLEAR: begin
                o_regions[0] = clip_rect('0, '0, full, full, sw_c, sh_c);
                o_pixel      = pack_rgb(i_cmd.clear_color, i_cfg.ch_pos, i_cfg.ch_size);
            end
            default: begin
                o_regions[0] = '0;
            end
        endcase
    end

endmodule
